>>> design/ctc_pkg.sv
package ctc_pkg;

  localparam int unsigned TICK_W = 64;
  localparam int unsigned SEC_W  = 64;
  localparam int unsigned FREQ_W = 35;
  localparam int unsigned NS_W   = 30;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [63:0] NS_PER_S = 64'd1000000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ       = 2'd0,
    CFG_OFFSET_SEC = 2'd1,
    CFG_OFFSET_NS  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              mode;
    logic [TICK_W-1:0] tick_count_in;
    logic [SEC_W-1:0]  seconds_in;
    logic [NS_W-1:0]   nanoseconds_in;
  } in_word_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_count_out;
    logic [SEC_W-1:0]  seconds_out;
    logic [NS_W-1:0]   nanoseconds_out;
  } out_word_t;

endpackage

>>> design/counter_time_converter.sv
// channel | direction | handshake                  | word
// in      | input     | in_valid_i / in_ready_o    | in_word_t (mode, ticks, time)
// out     | output    | out_valid_o / out_ready_i  | out_word_t (ticks, time)
// cfg     | input     | cfg_valid_i / cfg_ready_o  | index + 64-bit data
//
// one word per cycle unless the output stalls; stages: input register, 64-stage tick
// divider, 2-stage multiplier, 64-stage divider, output register
// the two restoring dividers (one quotient bit per stage) set the depth
// all stages advance together; a stalled output freezes the whole pipe
// reset clears valid bits and loads frequency 1 and a zero offset
module counter_time_converter import ctc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam int unsigned SIDE1_W = 1 + 64 + 64;
  localparam int unsigned SIDE2_W = 1 + 64;

  logic [FREQ_W-1:0] freq_q;
  logic [SEC_W-1:0]  off_sec_q;
  logic [NS_W-1:0]   off_ns_q;
  logic [FREQ_W-1:0] freq_eff;
  logic              en;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q    <= FREQ_W'(1);
      off_sec_q <= '0;
      off_ns_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FREQ:       freq_q    <= cfg_data_i[FREQ_W-1:0];
        CFG_OFFSET_SEC: off_sec_q <= cfg_data_i;
        CFG_OFFSET_NS:  off_ns_q  <= cfg_data_i[NS_W-1:0];
        default: ;
      endcase
    end
  end

  assign freq_eff = (freq_q == '0) ? FREQ_W'(1) : freq_q;

  // global advance: the pipe moves unless the output word is held
  logic out_vld_q;
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // input stage: offset subtraction for time to ticks
  logic              borrow;
  logic [63:0]       nsd;
  logic              vld0_q, mode0_q;
  logic [63:0]       ticks0_q, secs0_q, nsu0_q;

  assign borrow = (in_data_i.nanoseconds_in < off_ns_q);
  assign nsd    = 64'(in_data_i.nanoseconds_in) - 64'(off_ns_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode0_q  <= in_data_i.mode;
      ticks0_q <= in_data_i.tick_count_in;
      secs0_q  <= in_data_i.seconds_in - off_sec_q - 64'(borrow);
      nsu0_q   <= borrow ? nsd + NS_PER_S : nsd;
    end
  end

  // tick divider: whole seconds and remainder ticks
  logic               vld1;
  logic [63:0]        whole1;
  logic [FREQ_W-1:0]  rem1;
  logic [SIDE1_W-1:0] side1;
  logic               mode1;
  logic [63:0]        secs1, nsu1;

  ctc_div #(.NUM_W(TICK_W), .DEN_W(FREQ_W), .SIDE_W(SIDE1_W)) u_div_ticks (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld0_q),
    .num_i   (mode0_q ? 64'd0 : ticks0_q),
    .den_i   (freq_eff),
    .side_i  ({mode0_q, secs0_q, nsu0_q}),
    .valid_o (vld1),
    .quot_o  (whole1),
    .rem_o   (rem1),
    .side_o  (side1)
  );

  assign {mode1, secs1, nsu1} = side1;

  // multiplier: remainder or nanoseconds scaled, seconds times frequency
  logic               vld2;
  logic [63:0]        p0, p1;
  logic [SIDE2_W-1:0] side2;
  logic               mode2;
  logic [63:0]        whole2;

  ctc_mul #(.SIDE_W(SIDE2_W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld1),
    .a0_i    (mode1 ? nsu1 : 64'(rem1)),
    .b0_i    (mode1 ? freq_eff : FREQ_W'(NS_PER_S)),
    .a1_i    (secs1),
    .b1_i    (freq_eff),
    .side_i  ({mode1, whole1}),
    .valid_o (vld2),
    .p0_o    (p0),
    .p1_o    (p1),
    .side_o  (side2)
  );

  assign {mode2, whole2} = side2;

  // round-up divider: by frequency or by one billion
  logic [63:0]        num2;
  logic [FREQ_W-1:0]  den2;
  logic [63:0]        acc2;
  logic               vld3;
  logic [63:0]        quot3;
  logic [SIDE2_W-1:0] side3;
  logic               mode3;
  logic [63:0]        acc3;

  assign num2 = p0 + (mode2 ? NS_PER_S - 64'd1 : 64'(freq_eff) - 64'd1);
  assign den2 = mode2 ? FREQ_W'(NS_PER_S) : freq_eff;
  assign acc2 = mode2 ? p1 : whole2;

  ctc_div #(.NUM_W(TICK_W), .DEN_W(FREQ_W), .SIDE_W(SIDE2_W)) u_div_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld2),
    .num_i   (num2),
    .den_i   (den2),
    .side_i  ({mode2, acc2}),
    .valid_o (vld3),
    .quot_o  (quot3),
    .rem_o   (),
    .side_o  (side3)
  );

  assign {mode3, acc3} = side3;

  // final add: offset and one normalization step, or tick sum
  logic [63:0] ns_sum;
  logic        carry;
  logic [63:0] ns_norm;
  out_word_t   out_d, out_q;

  assign ns_sum  = 64'(off_ns_q) + quot3;
  assign carry   = (ns_sum >= NS_PER_S);
  assign ns_norm = carry ? ns_sum - NS_PER_S : ns_sum;

  always_comb begin
    out_d = '0;
    if (mode3) begin
      out_d.tick_count_out = acc3 + quot3;
    end else begin
      out_d.seconds_out     = off_sec_q + acc3 + 64'(carry);
      out_d.nanoseconds_out = ns_norm[NS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> design/ctc_div.sv
module ctc_div import ctc_pkg::*; #(
  parameter int unsigned NUM_W  = TICK_W,
  parameter int unsigned DEN_W  = FREQ_W,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quot_o,
  output logic [DEN_W-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);

  // one quotient bit per stage, msb first; dividend bits shift out as quotient bits shift in
  logic [NUM_W-1:0]  vld_q;
  logic [NUM_W-1:0]  nq_q   [NUM_W];
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic              vld_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DEN_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign nq_in   = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign nq_in   = nq_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    // trial subtract of the shifted partial remainder
    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_in});
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[i]   <= {nq_in[NUM_W-2:0], ge};
        rem_q[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quot_o  = nq_q[NUM_W-1];
  assign rem_o   = rem_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

>>> design/ctc_mul.sv
module ctc_mul import ctc_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [63:0]       a0_i,
  input  logic [FREQ_W-1:0] b0_i,
  input  logic [63:0]       a1_i,
  input  logic [FREQ_W-1:0] b1_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [63:0]       p0_o,
  output logic [63:0]       p1_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned PART_W = 16;
  localparam int unsigned PARTS  = 64 / PART_W;
  localparam int unsigned PP_W   = PART_W + FREQ_W;

  logic [PP_W-1:0]   pp0_q [PARTS];
  logic [PP_W-1:0]   pp1_q [PARTS];
  logic [SIDE_W-1:0] side1_q, side2_q;
  logic              vld1_q, vld2_q;
  logic [63:0]       sum0, sum1;
  logic [63:0]       p0_q, p1_q;

  // stage 1: narrow partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < PARTS; k++) begin
        pp0_q[k] <= PP_W'(a0_i[k*PART_W +: PART_W]) * PP_W'(b0_i);
        pp1_q[k] <= PP_W'(a1_i[k*PART_W +: PART_W]) * PP_W'(b1_i);
      end
      side1_q <= side_i;
    end
  end

  // stage 2: shifted sum, wraps at 64 bits
  always_comb begin
    sum0 = '0;
    sum1 = '0;
    for (int k = 0; k < PARTS; k++) begin
      sum0 = sum0 + (64'(pp0_q[k]) << (PART_W * k));
      sum1 = sum1 + (64'(pp1_q[k]) << (PART_W * k));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q    <= sum0;
      p1_q    <= sum1;
      side2_q <= side1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  assign valid_o = vld2_q;
  assign p0_o    = p0_q;
  assign p1_o    = p1_q;
  assign side_o  = side2_q;

endmodule

>>> tb/counter_time_converter_tb.sv
module counter_time_converter_tb;
  import ctc_pkg::*;

  localparam int unsigned LATENCY     = 132;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [63:0] FREQ_MAX    = 64'h7_FFFF_FFFF;
  localparam logic [63:0] NS_TOP      = 64'd999999999;

  // expected conversions, kept in acceptance order
  class conversion_board;
    logic [FREQ_W-1:0] freq;
    logic [63:0]       off_sec;
    logic [NS_W-1:0]   off_ns;
    out_word_t         expected_q[$];
    int unsigned       errors;
    int unsigned       matched;
    int unsigned       mode_seen[2];

    function new();
      freq = FREQ_W'(1);
      off_sec = '0;
      off_ns = '0;
      errors = 0;
      matched = 0;
      mode_seen[0] = 0;
      mode_seen[1] = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [63:0] data);
      case (idx)
        CFG_FREQ:       freq = data[FREQ_W-1:0];
        CFG_OFFSET_SEC: off_sec = data;
        CFG_OFFSET_NS:  off_ns = data[NS_W-1:0];
        default: ;
      endcase
    endfunction

    function out_word_t convert(in_word_t w);
      out_word_t r;
      logic [63:0] f, whole, rem, ns, secs, sum, nsu, prod;
      logic signed [63:0] nsd;
      r = '0;
      f = (freq == '0) ? 64'd1 : {{(64-FREQ_W){1'b0}}, freq};
      if (w.mode == 1'b0) begin
        // ticks to time, nanoseconds rounded up, one normalization step
        whole = w.tick_count_in / f;
        rem = w.tick_count_in - whole * f;
        ns = (rem * NS_PER_S + (f - 64'd1)) / f;
        secs = off_sec + whole;
        sum = {{(64-NS_W){1'b0}}, off_ns} + ns;
        if (sum >= NS_PER_S) begin
          sum = sum - NS_PER_S;
          secs = secs + 64'd1;
        end
        r.seconds_out = secs;
        r.nanoseconds_out = sum[NS_W-1:0];
      end else begin
        // time to ticks, borrow one second on negative nanoseconds
        secs = w.seconds_in - off_sec;
        nsd = $signed({{(64-NS_W){1'b0}}, w.nanoseconds_in})
              - $signed({{(64-NS_W){1'b0}}, off_ns});
        if (nsd < 0) begin
          secs = secs - 64'd1;
          nsd = nsd + $signed(NS_PER_S);
        end
        nsu = nsd;
        prod = secs * f;
        r.tick_count_out = prod + (nsu * f + (NS_PER_S - 64'd1)) / NS_PER_S;
      end
      return r;
    endfunction

    function void note_input(in_word_t w);
      expected_q.push_back(convert(w));
      mode_seen[w.mode]++;
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.tick_count_out !== exp_w.tick_count_out) begin
        $display("%0t: tick_count_out expected %h actual %h", $time,
                 exp_w.tick_count_out, got.tick_count_out);
        errors++;
      end
      if (got.seconds_out !== exp_w.seconds_out) begin
        $display("%0t: seconds_out expected %h actual %h", $time,
                 exp_w.seconds_out, got.seconds_out);
        errors++;
      end
      if (got.nanoseconds_out !== exp_w.nanoseconds_out) begin
        $display("%0t: nanoseconds_out expected %h actual %h", $time,
                 exp_w.nanoseconds_out, got.nanoseconds_out);
        errors++;
      end
      matched++;
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_word_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_word_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [63:0]          cfg_data_i;

  conversion_board board;
  int unsigned     cycle_cnt = 0;
  int unsigned     burst_left;
  int unsigned     hold_left = 0;
  bit              hold_req;
  bit              no_gaps;
  int unsigned     stall_style = 0;

  counter_time_converter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  // handshake monitors
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        board.write_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
      end
      if (in_valid_i && in_ready_o) begin
        board.note_input(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        board.check_result(out_data_o);
      end
    end
  end

  // receiver stalls: long hold-off on request, otherwise a changing pattern
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= (hold_left == 1);
    end else begin
      if ((cycle_cnt % 256) == 0) begin
        stall_style <= $urandom_range(0, 3);
      end
      case (stall_style)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 9) < 7);
        2: out_ready_i <= (cycle_cnt % 5) != 0;
        default: out_ready_i <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // one register write; valid stays up for a following write
  task automatic write_cfg(cfg_idx_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_config(logic [63:0] freq, logic [63:0] sec, logic [63:0] ns);
    write_cfg(CFG_FREQ, freq);
    write_cfg(CFG_OFFSET_SEC, sec);
    write_cfg(CFG_OFFSET_NS, ns);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // send one word, then maybe a gap between bursts
  task automatic send_word(in_word_t w);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else if (!no_gaps) begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  function automatic in_word_t make_word(bit m, logic [63:0] t, logic [63:0] s,
                                         logic [NS_W-1:0] n);
    in_word_t w;
    w.mode = m;
    w.tick_count_in = t;
    w.seconds_in = s;
    w.nanoseconds_in = n;
    return w;
  endfunction

  function automatic in_word_t random_word();
    logic [63:0] t, s;
    logic [NS_W-1:0] n;
    case ($urandom_range(0, 3))
      0: t = 64'($urandom_range(0, 100000));
      1: t = {32'd0, $urandom};
      default: t = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 3))
      0: s = 64'($urandom_range(0, 1000));
      1: s = -64'($urandom_range(0, 1000));
      default: s = {$urandom, $urandom};
    endcase
    if ($urandom_range(0, 7) == 0) n = NS_W'($urandom);
    else n = NS_W'($urandom_range(0, 999999999));
    return make_word(1'($urandom_range(0, 1)), t, s, n);
  endfunction

  in_word_t directed_q[$];
  logic [63:0] freq_set[8];
  logic [63:0] sec_set[8];
  logic [63:0] ns_set[8];

  initial begin
    board = new();
    burst_left = 0;
    hold_req = 0;
    no_gaps = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FREQ;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes, carries, borrows, out of range nanoseconds
    directed_q.push_back(make_word(1'b0, 64'd0, 64'd0, '0));
    directed_q.push_back(make_word(1'b0, '1, '0, '0));
    directed_q.push_back(make_word(1'b0, 64'd1, '0, '0));
    directed_q.push_back(make_word(1'b0, 64'd2, '0, '0));
    directed_q.push_back(make_word(1'b0, 64'd3000000000, '0, '0));
    directed_q.push_back(make_word(1'b0, 64'h8000_0000_0000_0000, '0, '0));
    directed_q.push_back(make_word(1'b1, '0, 64'd0, 30'd0));
    directed_q.push_back(make_word(1'b1, '0, 64'h7FFF_FFFF_FFFF_FFFF, 30'd999999999));
    directed_q.push_back(make_word(1'b1, '0, 64'h8000_0000_0000_0000, 30'd0));
    directed_q.push_back(make_word(1'b1, '0, '1, '1));
    directed_q.push_back(make_word(1'b1, '0, 64'd5, 30'd1));
    directed_q.push_back(make_word(1'b1, '0, 64'd5, 30'd999999998));
    directed_q.push_back(make_word(1'b1, '1, 64'd0, 30'h3FFF_FFFF));
    directed_q.push_back(make_word(1'b0, 64'd7, '1, '1));

    freq_set[0] = 64'd1;         sec_set[0] = '0;    ns_set[0] = '0;
    freq_set[1] = 64'd3;         sec_set[1] = 64'd100;
    ns_set[1] = NS_TOP;
    freq_set[2] = 64'd0;         sec_set[2] = 64'h7FFF_FFFF_FFFF_FFFF;
    ns_set[2] = 64'd1;
    freq_set[3] = FREQ_MAX;      sec_set[3] = 64'h8000_0000_0000_0000;
    ns_set[3] = 64'd500000000;
    freq_set[4] = '1;            sec_set[4] = '1;
    ns_set[4] = 64'h3FFF_FFFF;
    freq_set[5] = 64'd1000000000; sec_set[5] = -64'd5;
    ns_set[5] = 64'hFFFF_FFFF_C000_0000;
    freq_set[6] = 64'd19200000;  sec_set[6] = {$urandom, $urandom};
    ns_set[6] = 64'($urandom_range(0, 999999999));
    freq_set[7] = {$urandom_range(0, 7), $urandom}; sec_set[7] = {$urandom, $urandom};
    ns_set[7] = 64'($urandom);

    for (int p = 0; p < 8; p++) begin
      if (p > 0) set_config(freq_set[p], sec_set[p], ns_set[p]);
      if (p == 1 || p == 3) begin
        foreach (directed_q[i]) send_word(directed_q[i]);
      end
      // long receiver hold-off while the sender keeps pushing
      if (p == 4) begin
        no_gaps = 1;
        hold_req = 1;
      end
      for (int i = 0; i < 160; i++) begin
        send_word(random_word());
        if (hold_req && hold_left != 0) hold_req = 0;
      end
      no_gaps = 0;
      hold_req = 0;
      wait_idle();
    end

    $display("covered %0d ticks-to-time and %0d time-to-ticks words over 8 settings",
             board.mode_seen[0], board.mode_seen[1]);
    $display("%0d results checked, %0d mismatches", board.matched, board.errors);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ctc_pkg.sv
design/ctc_div.sv
design/ctc_mul.sv
design/counter_time_converter.sv
tb/counter_time_converter_tb.sv
